>>> design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/hrp_pkg.sv
// Shared types and constants of the request head parser
package hrp_pkg;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int REG_LEN_MAX = 8191;

    localparam logic [6:0]  RST_MAX_METHOD_LEN      = 7'd32;
    localparam logic [12:0] RST_MAX_URL_LEN         = 13'd2048;
    localparam logic [6:0]  RST_MAX_VERSION_LEN     = 7'd16;
    localparam logic [12:0] RST_MAX_HEADER_LINE_LEN = 13'd2047;

    typedef enum logic [1:0] {
        REG_MAX_METHOD_LEN      = 2'd0,
        REG_MAX_URL_LEN         = 2'd1,
        REG_MAX_VERSION_LEN     = 2'd2,
        REG_MAX_HEADER_LINE_LEN = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CL_METHOD = 3'd0,
        CL_URL    = 3'd1,
        CL_VER    = 3'd2,
        CL_NAME   = 3'd3,
        CL_COLON  = 3'd4,
        CL_SKIP   = 3'd5,
        CL_VALUE  = 3'd6,
        CL_DELIM  = 3'd7
    } class_t;

    typedef enum logic [3:0] {
        ST_BUSY       = 4'd0,
        ST_DONE       = 4'd1,
        ST_METHOD_LONG = 4'd2,
        ST_URL_LONG   = 4'd3,
        ST_VER_LONG   = 4'd4,
        ST_HDR_LONG   = 4'd5,
        ST_BAD_URL    = 4'd6,
        ST_NO_LF_REQ  = 4'd7,
        ST_NO_LF_HDR  = 4'd8,
        ST_NO_LF_END  = 4'd9,
        ST_HDR_FORMAT = 4'd10
    } status_t;

    typedef struct packed {
        logic [6:0]  max_method_len;
        logic [12:0] max_url_len;
        logic [6:0]  max_version_len;
        logic [12:0] max_header_line_len;
    } cfg_regs_t;

    typedef struct packed {
        class_t      byte_class;
        logic [11:0] field_position;
        logic [7:0]  header_index;
        status_t     status;
    } result_t;

endpackage

>>> design/hrp_cfg.sv
// Limit register file written through the configuration channel
module hrp_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    output hrp_pkg::cfg_regs_t  regs
);

    hrp_pkg::cfg_regs_t regs_reg;
    hrp_pkg::cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            unique case (hrp_pkg::cfg_reg_t'(cfg_index))
                hrp_pkg::REG_MAX_METHOD_LEN:
                    regs_next.max_method_len = cfg_data[6:0];
                hrp_pkg::REG_MAX_URL_LEN:
                    regs_next.max_url_len = cfg_data;
                hrp_pkg::REG_MAX_VERSION_LEN:
                    regs_next.max_version_len = cfg_data[6:0];
                hrp_pkg::REG_MAX_HEADER_LINE_LEN:
                    regs_next.max_header_line_len = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.max_method_len      <= hrp_pkg::RST_MAX_METHOD_LEN;
            regs_reg.max_url_len         <= hrp_pkg::RST_MAX_URL_LEN;
            regs_reg.max_version_len     <= hrp_pkg::RST_MAX_VERSION_LEN;
            regs_reg.max_header_line_len <= hrp_pkg::RST_MAX_HEADER_LINE_LEN;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

>>> design/hrp_core.sv
// Parse state and per-byte classification logic
module hrp_core
#(
    parameter int FIELD_LEN_LIMIT  = 4096,
    parameter int HEADER_COUNT_MAX = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  hrp_pkg::cfg_regs_t cfg,
    output hrp_pkg::result_t   result
);

    localparam int LEN_MAX = (FIELD_LEN_LIMIT < hrp_pkg::REG_LEN_MAX) ?
                             FIELD_LEN_LIMIT : hrp_pkg::REG_LEN_MAX;
    localparam int FL_W    = $clog2(LEN_MAX + 1);
    localparam int HC_W    = $clog2(HEADER_COUNT_MAX + 1);

    typedef enum logic [7:0] {
        PH_METHOD    = 8'b0000_0001,
        PH_URL       = 8'b0000_0010,
        PH_VER       = 8'b0000_0100,
        PH_VER_LF    = 8'b0000_1000,
        PH_HDR_START = 8'b0001_0000,
        PH_LINE      = 8'b0010_0000,
        PH_LINE_LF   = 8'b0100_0000,
        PH_END_LF    = 8'b1000_0000
    } phase_t;

    function automatic logic [FL_W-1:0] cap_limit(input logic [12:0] r);
        if (32'(r) < 32'(FIELD_LEN_LIMIT))
            return FL_W'(r);
        else
            return FL_W'(FIELD_LEN_LIMIT);
    endfunction

    phase_t            phase_reg, phase_next;
    logic [FL_W-1:0]   fl_reg, fl_next;
    logic              bad_url_reg, bad_url_next;
    logic              colon_seen_reg, colon_seen_next;
    logic              prev_colon_reg, prev_colon_next;
    logic [HC_W-1:0]   hdr_cnt_reg, hdr_cnt_next;

    logic [FL_W-1:0]   lim_method, lim_url, lim_ver, lim_hdr;
    logic [FL_W-1:0]   pos_src;
    logic [FL_W-1:0]   line_fl;
    logic              line_cs;
    logic              line_pc;
    logic              line_mode;
    hrp_pkg::class_t   cls;
    hrp_pkg::status_t  st;

    assign lim_method = cap_limit({6'd0, cfg.max_method_len});
    assign lim_url    = cap_limit(cfg.max_url_len);
    assign lim_ver    = cap_limit({6'd0, cfg.max_version_len});
    assign lim_hdr    = cap_limit(cfg.max_header_line_len);

    always_comb
    begin
        phase_next      = phase_reg;
        fl_next         = fl_reg;
        bad_url_next    = bad_url_reg;
        colon_seen_next = colon_seen_reg;
        prev_colon_next = prev_colon_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        cls             = hrp_pkg::CL_DELIM;
        st              = hrp_pkg::ST_BUSY;
        pos_src         = fl_reg;
        line_fl         = fl_reg;
        line_cs         = colon_seen_reg;
        line_pc         = prev_colon_reg;
        line_mode       = 1'b0;

        unique case (phase_reg)
            PH_URL:
            begin
                if (in_byte == hrp_pkg::CH_SP)
                begin
                    if (fl_reg == '0 || bad_url_reg)
                        st = hrp_pkg::ST_BAD_URL;
                    else
                    begin
                        phase_next = PH_VER;
                        fl_next    = '0;
                    end
                end
                else
                begin
                    cls = hrp_pkg::CL_URL;
                    if (fl_reg >= lim_url)
                        st = hrp_pkg::ST_URL_LONG;
                    else
                    begin
                        if (fl_reg == '0 && in_byte != hrp_pkg::CH_SLASH)
                            bad_url_next = 1'b1;
                        fl_next = fl_reg + FL_W'(1);
                    end
                end
            end
            PH_VER:
            begin
                if (in_byte == hrp_pkg::CH_CR)
                    phase_next = PH_VER_LF;
                else
                begin
                    cls = hrp_pkg::CL_VER;
                    if (fl_reg >= lim_ver)
                        st = hrp_pkg::ST_VER_LONG;
                    else
                        fl_next = fl_reg + FL_W'(1);
                end
            end
            PH_VER_LF:
            begin
                if (in_byte != hrp_pkg::CH_LF)
                    st = hrp_pkg::ST_NO_LF_REQ;
                else
                begin
                    phase_next = PH_HDR_START;
                    fl_next    = '0;
                end
            end
            PH_HDR_START:
            begin
                pos_src = '0;
                if (in_byte == hrp_pkg::CH_CR)
                    phase_next = PH_END_LF;
                else
                begin
                    phase_next = PH_LINE;
                    line_fl    = '0;
                    line_cs    = 1'b0;
                    line_pc    = 1'b0;
                    line_mode  = 1'b1;
                end
            end
            PH_LINE:
            begin
                if (in_byte == hrp_pkg::CH_CR)
                    phase_next = PH_LINE_LF;
                else
                    line_mode = 1'b1;
            end
            PH_LINE_LF:
            begin
                if (in_byte != hrp_pkg::CH_LF)
                    st = hrp_pkg::ST_NO_LF_HDR;
                else if (!colon_seen_reg || prev_colon_reg)
                    st = hrp_pkg::ST_HDR_FORMAT;
                else
                begin
                    if (32'(hdr_cnt_reg) < 32'(HEADER_COUNT_MAX))
                        hdr_cnt_next = hdr_cnt_reg + HC_W'(1);
                    phase_next = PH_HDR_START;
                    fl_next    = '0;
                end
            end
            PH_END_LF:
            begin
                pos_src = '0;
                if (in_byte == hrp_pkg::CH_LF)
                    st = hrp_pkg::ST_DONE;
                else
                    st = hrp_pkg::ST_NO_LF_END;
            end
            default:
            begin
                phase_next = PH_METHOD;
                if (in_byte == hrp_pkg::CH_SP)
                begin
                    phase_next   = PH_URL;
                    fl_next      = '0;
                    bad_url_next = 1'b0;
                end
                else
                begin
                    cls = hrp_pkg::CL_METHOD;
                    if (fl_reg >= lim_method)
                        st = hrp_pkg::ST_METHOD_LONG;
                    else
                        fl_next = fl_reg + FL_W'(1);
                end
            end
        endcase

        if (line_mode)
        begin
            colon_seen_next = line_cs;
            prev_colon_next = line_pc;
            if (!line_cs)
            begin
                if (in_byte == hrp_pkg::CH_COLON)
                begin
                    cls             = hrp_pkg::CL_COLON;
                    colon_seen_next = 1'b1;
                    prev_colon_next = 1'b1;
                end
                else
                    cls = hrp_pkg::CL_NAME;
            end
            else if (line_pc)
            begin
                cls             = hrp_pkg::CL_SKIP;
                prev_colon_next = 1'b0;
            end
            else
                cls = hrp_pkg::CL_VALUE;
            if (line_fl >= lim_hdr)
                st = hrp_pkg::ST_HDR_LONG;
            else
                fl_next = line_fl + FL_W'(1);
        end
    end

    always_comb
    begin
        result.byte_class     = cls;
        result.field_position = (32'(pos_src) > 32'd4095) ? 12'd4095 : 12'(pos_src);
        result.header_index   = 8'(hdr_cnt_next);
        result.status         = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_METHOD;
            fl_reg         <= '0;
            bad_url_reg    <= 1'b0;
            colon_seen_reg <= 1'b0;
            prev_colon_reg <= 1'b0;
            hdr_cnt_reg    <= '0;
        end
        else if (step)
        begin
            if (st != hrp_pkg::ST_BUSY)
            begin
                // restart for the next request
                phase_reg      <= PH_METHOD;
                fl_reg         <= '0;
                bad_url_reg    <= 1'b0;
                colon_seen_reg <= 1'b0;
                prev_colon_reg <= 1'b0;
                hdr_cnt_reg    <= '0;
            end
            else
            begin
                phase_reg      <= phase_next;
                fl_reg         <= fl_next;
                bad_url_reg    <= bad_url_next;
                colon_seen_reg <= colon_seen_next;
                prev_colon_reg <= prev_colon_next;
                hdr_cnt_reg    <= hdr_cnt_next;
            end
        end
    end

endmodule

>>> design/http_request_head_parser.sv
// Pipeline: a byte accepted into the input register moves on to the output register
// when that is empty or being read. Throughput: one byte per cycle while out_ready
// holds; the parse state advances with each byte that moves to the result register.
// Reset: asynchronous, active low; clears the parse state and both pipeline
// valids, and loads the limit registers with their defaults.
// Top level of the request head parser
module http_request_head_parser
#(
    parameter int FIELD_LEN_LIMIT  = 4096,
    parameter int HEADER_COUNT_MAX = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [2:0]  byte_class,
    output logic [11:0] field_position,
    output logic [7:0]  header_index,
    output logic [3:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    hrp_pkg::cfg_regs_t cfg_regs;
    hrp_pkg::result_t   core_result;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    hrp_pkg::result_t   out_result_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    hrp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg_regs)
    );

    hrp_core
    #(
        .FIELD_LEN_LIMIT  (FIELD_LEN_LIMIT),
        .HEADER_COUNT_MAX (HEADER_COUNT_MAX)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .cfg     (cfg_regs),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= in_byte;
        if (advance)
        begin
            out_byte_reg   <= in_byte_reg;
            out_result_reg <= core_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_class     = out_result_reg.byte_class;
    assign field_position = out_result_reg.field_position;
    assign header_index   = out_result_reg.header_index;
    assign status         = out_result_reg.status;

endmodule

>>> design/hrp_checker.sv
// Port-level checks on the request head parser, bound to the top level
`include "assert_macros.svh"

module hrp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic [2:0]  byte_class,
    input  logic [11:0] field_position,
    input  logic [3:0]  status
);

    `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status), "stalled result changed")
    `CHK_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")
    `CHK_ASSERT(a_done_on_lf, clk, rst_n, out_valid && status == hrp_pkg::ST_DONE |-> byte_class == hrp_pkg::CL_DELIM && out_byte == hrp_pkg::CH_LF && field_position == 12'd0, "done not on blank line LF")
    `CHK_ASSERT(a_colon_class, clk, rst_n, out_valid && byte_class == hrp_pkg::CL_COLON |-> out_byte == hrp_pkg::CH_COLON, "colon class on other byte")
    `CHK_ASSERT(a_status_range, clk, rst_n, out_valid |-> status <= hrp_pkg::ST_HDR_FORMAT, "status code out of range")

endmodule

bind http_request_head_parser hrp_checker u_hrp_checker (.*);

>>> sim/http_request_head_parser_test.sv
// Self-checking testbench for the HTTP request head parser: byte stream in, byte verdicts out
module http_request_head_parser_test;

    localparam int unsigned FIELD_CAP    = 4096;
    localparam int unsigned HDR_SAT      = 255;
    localparam int unsigned RANDOM_BYTES = 330;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef enum logic [3:0] {
        P_METHOD,
        P_URL,
        P_VER,
        P_VER_LF,
        P_HDR_START,
        P_LINE,
        P_LINE_LF,
        P_END_LF
    } parse_phase_t;

    typedef struct packed {
        logic [7:0]        data;
        hrp_pkg::class_t   cls;
        logic [11:0]       pos;
        logic [7:0]        hidx;
        hrp_pkg::status_t  st;
    } byte_verdict_t;

    typedef struct packed {
        bit                 is_cfg;
        bit                 typed;
        hrp_pkg::cfg_reg_t  idx;
        logic [12:0]        value;
        byte_verdict_t      want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic [2:0]  byte_class;
    logic [11:0] field_position;
    logic [7:0]  header_index;
    logic [3:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    logic [6:0]  lim_method  = hrp_pkg::RST_MAX_METHOD_LEN;
    logic [12:0] lim_url     = hrp_pkg::RST_MAX_URL_LEN;
    logic [6:0]  lim_version = hrp_pkg::RST_MAX_VERSION_LEN;
    logic [12:0] lim_line    = hrp_pkg::RST_MAX_HEADER_LINE_LEN;

    parse_phase_t ph = P_METHOD;
    int unsigned  flen = 0;
    bit           url_bad = 1'b0;
    bit           colon_seen = 1'b0;
    bit           after_colon = 1'b0;
    int unsigned  hdr_count = 0;

    byte_verdict_t byte_verdicts[$];
    int unsigned   bytes_sent = 0;
    int unsigned   burst_left = 0;
    int unsigned   cycles = 0;
    bit            failed = 1'b0;

    http_request_head_parser DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_class     (byte_class),
        .field_position (field_position),
        .header_index   (header_index),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    function automatic int unsigned capped(input int unsigned r);
        return (r < FIELD_CAP) ? r : FIELD_CAP;
    endfunction

    function automatic void reset_parse();
        ph          = P_METHOD;
        flen        = 0;
        url_bad     = 1'b0;
        colon_seen  = 1'b0;
        after_colon = 1'b0;
        hdr_count   = 0;
    endfunction

    function automatic byte_verdict_t classify_byte(input logic [7:0] b);
        byte_verdict_t v;
        int unsigned   pos;
        v.data = b;
        v.cls  = hrp_pkg::CL_DELIM;
        v.st   = hrp_pkg::ST_BUSY;
        pos    = flen;
        case (ph)
            P_URL:
            begin
                if (b == hrp_pkg::CH_SP)
                begin
                    if (flen == 0 || url_bad)
                        v.st = hrp_pkg::ST_BAD_URL;
                    else
                    begin
                        ph   = P_VER;
                        flen = 0;
                    end
                end
                else
                begin
                    v.cls = hrp_pkg::CL_URL;
                    if (flen >= capped(lim_url))
                        v.st = hrp_pkg::ST_URL_LONG;
                    else
                    begin
                        if (flen == 0 && b != hrp_pkg::CH_SLASH)
                            url_bad = 1'b1;
                        flen++;
                    end
                end
            end
            P_VER:
            begin
                if (b == hrp_pkg::CH_CR)
                    ph = P_VER_LF;
                else
                begin
                    v.cls = hrp_pkg::CL_VER;
                    if (flen >= capped(lim_version))
                        v.st = hrp_pkg::ST_VER_LONG;
                    else
                        flen++;
                end
            end
            P_VER_LF:
            begin
                if (b != hrp_pkg::CH_LF)
                    v.st = hrp_pkg::ST_NO_LF_REQ;
                else
                begin
                    ph   = P_HDR_START;
                    flen = 0;
                end
            end
            P_HDR_START, P_LINE:
            begin
                if (b == hrp_pkg::CH_CR)
                begin
                    if (ph == P_HDR_START)
                    begin
                        pos = 0;
                        ph  = P_END_LF;
                    end
                    else
                        ph = P_LINE_LF;
                end
                else
                begin
                    if (ph == P_HDR_START)
                    begin
                        ph          = P_LINE;
                        flen        = 0;
                        colon_seen  = 1'b0;
                        after_colon = 1'b0;
                        pos         = 0;
                    end
                    if (!colon_seen)
                    begin
                        if (b == hrp_pkg::CH_COLON)
                        begin
                            v.cls       = hrp_pkg::CL_COLON;
                            colon_seen  = 1'b1;
                            after_colon = 1'b1;
                        end
                        else
                            v.cls = hrp_pkg::CL_NAME;
                    end
                    else if (after_colon)
                    begin
                        v.cls       = hrp_pkg::CL_SKIP;
                        after_colon = 1'b0;
                    end
                    else
                        v.cls = hrp_pkg::CL_VALUE;
                    if (flen >= capped(lim_line))
                        v.st = hrp_pkg::ST_HDR_LONG;
                    else
                        flen++;
                end
            end
            P_LINE_LF:
            begin
                if (b != hrp_pkg::CH_LF)
                    v.st = hrp_pkg::ST_NO_LF_HDR;
                else if (!colon_seen || after_colon)
                    v.st = hrp_pkg::ST_HDR_FORMAT;
                else
                begin
                    if (hdr_count < HDR_SAT)
                        hdr_count++;
                    ph   = P_HDR_START;
                    flen = 0;
                end
            end
            P_END_LF:
            begin
                pos  = 0;
                v.st = (b == hrp_pkg::CH_LF) ? hrp_pkg::ST_DONE : hrp_pkg::ST_NO_LF_END;
            end
            default:
            begin
                ph = P_METHOD;
                if (b == hrp_pkg::CH_SP)
                begin
                    ph      = P_URL;
                    flen    = 0;
                    url_bad = 1'b0;
                end
                else
                begin
                    v.cls = hrp_pkg::CL_METHOD;
                    if (flen >= capped(lim_method))
                        v.st = hrp_pkg::ST_METHOD_LONG;
                    else
                        flen++;
                end
            end
        endcase
        v.pos  = (pos > 4095) ? 12'd4095 : 12'(pos);
        v.hidx = 8'(hdr_count);
        if (v.st != hrp_pkg::ST_BUSY)
            reset_parse();
        return v;
    endfunction

    function automatic logic [7:0] other_byte(input logic [7:0] x1, input logic [7:0] x2);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == x1 || b == x2);
        return b;
    endfunction

    function automatic int unsigned field_len(input int unsigned lim);
        int unsigned eff;
        eff = capped(lim);
        if (eff <= 16 && $urandom_range(0, 3) == 0)
            return eff + $urandom_range(0, 1);
        return $urandom_range(0, (eff < 5) ? eff : 5);
    endfunction

    function automatic logic [12:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return 13'd0;
            1: return 13'd1;
            2, 3: return 13'($urandom_range(2, 12));
            4, 5: return 13'($urandom_range(13, 64));
            6: return 13'($urandom);
            default: return 13'h1FFF;
        endcase
    endfunction

    function automatic stim_row_t feed(input logic [7:0] b);
        stim_row_t r;
        r = '0;
        r.want.data = b;
        return r;
    endfunction

    function automatic stim_row_t feed_check(input logic [7:0] b,
                                             input hrp_pkg::class_t c,
                                             input int unsigned p, input int unsigned h,
                                             input hrp_pkg::status_t s);
        stim_row_t r;
        r = feed(b);
        r.typed     = 1'b1;
        r.want.cls  = c;
        r.want.pos  = 12'(p);
        r.want.hidx = 8'(h);
        r.want.st   = s;
        return r;
    endfunction

    function automatic stim_row_t reg_write(input hrp_pkg::cfg_reg_t i,
                                            input logic [12:0] value);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = i;
        r.value  = value;
        return r;
    endfunction

    // Send one byte in bursts with random gaps; start and end at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        byte_verdicts.push_back(classify_byte(b));
        bytes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain_parser();
        in_valid <= 1'b0;
        burst_left = 0;
        while (byte_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input hrp_pkg::cfg_reg_t idx, input logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            hrp_pkg::REG_MAX_METHOD_LEN:  lim_method  = value[6:0];
            hrp_pkg::REG_MAX_URL_LEN:     lim_url     = value;
            hrp_pkg::REG_MAX_VERSION_LEN: lim_version = value[6:0];
            default:                      lim_line    = value;
        endcase
        @(negedge clk);
    endtask

    task automatic set_limits(input logic [12:0] m, input logic [12:0] u,
                              input logic [12:0] v, input logic [12:0] h);
        drain_parser();
        write_reg(hrp_pkg::REG_MAX_METHOD_LEN, m);
        write_reg(hrp_pkg::REG_MAX_URL_LEN, u);
        write_reg(hrp_pkg::REG_MAX_VERSION_LEN, v);
        write_reg(hrp_pkg::REG_MAX_HEADER_LINE_LEN, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_header_line();
        int unsigned kind;
        kind = $urandom_range(0, 11);
        repeat ($urandom_range(0, 4)) send_byte(other_byte(hrp_pkg::CH_COLON, hrp_pkg::CH_CR));
        if (kind != 0)
            send_byte(hrp_pkg::CH_COLON);
        if (kind > 1)
        begin
            send_byte(other_byte(hrp_pkg::CH_CR, hrp_pkg::CH_CR));
            repeat (field_len(lim_line)) send_byte(other_byte(hrp_pkg::CH_CR, hrp_pkg::CH_CR));
        end
        send_byte(hrp_pkg::CH_CR);
        send_byte(($urandom_range(0, 24) == 0) ? other_byte(hrp_pkg::CH_LF, hrp_pkg::CH_LF)
                                               : hrp_pkg::CH_LF);
    endtask

    task automatic send_request();
        int unsigned n;
        repeat (field_len(lim_method)) send_byte(other_byte(hrp_pkg::CH_SP, hrp_pkg::CH_SP));
        send_byte(hrp_pkg::CH_SP);
        n = field_len(lim_url);
        if (n == 0 && $urandom_range(0, 7) != 0)
            n = 1;
        if (n > 0)
        begin
            send_byte(($urandom_range(0, 9) == 0)
                      ? other_byte(hrp_pkg::CH_SP, hrp_pkg::CH_SLASH) : hrp_pkg::CH_SLASH);
            repeat (n - 1) send_byte(other_byte(hrp_pkg::CH_SP, hrp_pkg::CH_SP));
        end
        send_byte(hrp_pkg::CH_SP);
        repeat (field_len(lim_version)) send_byte(other_byte(hrp_pkg::CH_CR, hrp_pkg::CH_CR));
        send_byte(hrp_pkg::CH_CR);
        send_byte(($urandom_range(0, 19) == 0) ? other_byte(hrp_pkg::CH_LF, hrp_pkg::CH_LF)
                                               : hrp_pkg::CH_LF);
        repeat ($urandom_range(0, 4)) send_header_line();
        send_byte(hrp_pkg::CH_CR);
        send_byte(($urandom_range(0, 19) == 0) ? other_byte(hrp_pkg::CH_LF, hrp_pkg::CH_LF)
                                               : hrp_pkg::CH_LF);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: switch between no stalls, random stalls and alternating stalls
    initial
    begin
        int unsigned rx_mode;
        int unsigned rx_left;
        bit          rx_toggle;
        out_ready = 1'b0;
        rx_mode   = 0;
        rx_left   = 0;
        rx_toggle = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(64, 256);
            end
            rx_left--;
            rx_toggle = ~rx_toggle;
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= rx_toggle;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        byte_verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (byte_verdicts.size() == 0)
            begin
                $error("result with nothing expected: out_byte %0d", out_byte);
                failed = 1'b1;
            end
            else
            begin
                want = byte_verdicts.pop_front();
                report_field("out_byte", want.data, out_byte);
                report_field("byte_class", want.cls, byte_class);
                report_field("field_position", want.pos, field_position);
                report_field("header_index", want.hidx, header_index);
                report_field("status", want.st, status);
            end
        end
    end

    initial
    begin
        stim_row_t   dir_rows[$];
        int unsigned random_end;
        int unsigned next_reconfig;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = hrp_pkg::REG_MAX_METHOD_LEN;
        cfg_data  = 13'd0;

        dir_rows.push_back(feed_check(8'hFF, hrp_pkg::CL_METHOD, 0, 0, hrp_pkg::ST_BUSY));
        dir_rows.push_back(feed(hrp_pkg::CH_SP));
        dir_rows.push_back(feed(8'h00));
        dir_rows.push_back(feed_check(hrp_pkg::CH_SP, hrp_pkg::CL_DELIM, 1, 0,
                                      hrp_pkg::ST_BAD_URL));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_METHOD_LEN, 13'd0));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_URL_LEN, 13'd1));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_VERSION_LEN, 13'd0));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_HEADER_LINE_LEN, 13'd3));
        dir_rows.push_back(feed_check("G", hrp_pkg::CL_METHOD, 0, 0, hrp_pkg::ST_METHOD_LONG));
        dir_rows.push_back(feed(hrp_pkg::CH_SP));
        dir_rows.push_back(feed(hrp_pkg::CH_SLASH));
        dir_rows.push_back(feed_check(hrp_pkg::CH_SLASH, hrp_pkg::CL_URL, 1, 0,
                                      hrp_pkg::ST_URL_LONG));
        dir_rows.push_back(feed(hrp_pkg::CH_SP));
        dir_rows.push_back(feed(hrp_pkg::CH_SLASH));
        dir_rows.push_back(feed(hrp_pkg::CH_SP));
        dir_rows.push_back(feed(hrp_pkg::CH_CR));
        dir_rows.push_back(feed(hrp_pkg::CH_LF));
        dir_rows.push_back(feed("a"));
        dir_rows.push_back(feed(hrp_pkg::CH_COLON));
        dir_rows.push_back(feed("b"));
        dir_rows.push_back(feed(hrp_pkg::CH_CR));
        dir_rows.push_back(feed(hrp_pkg::CH_LF));
        dir_rows.push_back(feed(hrp_pkg::CH_COLON));
        dir_rows.push_back(feed(hrp_pkg::CH_CR));
        dir_rows.push_back(feed_check(hrp_pkg::CH_LF, hrp_pkg::CL_DELIM, 1, 1,
                                      hrp_pkg::ST_HDR_FORMAT));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_METHOD_LEN, 13'h1FFF));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_URL_LEN, 13'h1FFF));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_VERSION_LEN, 13'h007F));
        dir_rows.push_back(reg_write(hrp_pkg::REG_MAX_HEADER_LINE_LEN, 13'h1FFF));
        dir_rows.push_back(feed(hrp_pkg::CH_SP));
        dir_rows.push_back(feed(hrp_pkg::CH_SLASH));
        dir_rows.push_back(feed(hrp_pkg::CH_SP));
        dir_rows.push_back(feed(hrp_pkg::CH_CR));
        dir_rows.push_back(feed(hrp_pkg::CH_LF));
        dir_rows.push_back(feed(hrp_pkg::CH_CR));
        dir_rows.push_back(feed_check(hrp_pkg::CH_LF, hrp_pkg::CL_DELIM, 0, 0,
                                      hrp_pkg::ST_DONE));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].is_cfg)
            begin
                if (i == 0 || !dir_rows[i - 1].is_cfg)
                    drain_parser();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
                if (i + 1 == dir_rows.size() || !dir_rows[i + 1].is_cfg)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                send_byte(dir_rows[i].want.data);
                if (dir_rows[i].typed)
                    byte_verdicts[byte_verdicts.size() - 1] = dir_rows[i].want;
            end
        end

        random_end    = bytes_sent + RANDOM_BYTES;
        next_reconfig = bytes_sent;
        while (bytes_sent < random_end)
        begin
            if (bytes_sent >= next_reconfig)
            begin
                set_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
                next_reconfig = bytes_sent + $urandom_range(120, 300);
            end
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    case ($urandom_range(0, 5))
                        0:       send_byte(hrp_pkg::CH_SP);
                        1:       send_byte(hrp_pkg::CH_CR);
                        2:       send_byte(hrp_pkg::CH_LF);
                        3:       send_byte(hrp_pkg::CH_COLON);
                        4:       send_byte(hrp_pkg::CH_SLASH);
                        default: send_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else
                send_request();
        end

        // Header count ceiling; first drive the parser back to the start of a request
        set_limits(13'd5, 13'h1FFF, 13'd8, 13'h1FFF);
        while (ph != P_METHOD || flen != 0)
            send_byte((ph == P_HDR_START || ph == P_LINE) ? hrp_pkg::CH_CR : hrp_pkg::CH_SP);
        send_byte("G");
        send_byte(hrp_pkg::CH_SP);
        send_byte(hrp_pkg::CH_SLASH);
        send_byte(hrp_pkg::CH_SP);
        send_byte(hrp_pkg::CH_CR);
        send_byte(hrp_pkg::CH_LF);
        repeat (258)
        begin
            send_byte(hrp_pkg::CH_COLON);
            send_byte("b");
            send_byte(hrp_pkg::CH_CR);
            send_byte(hrp_pkg::CH_LF);
        end
        send_byte(hrp_pkg::CH_CR);
        send_byte(hrp_pkg::CH_LF);

        in_valid <= 1'b0;
        while (byte_verdicts.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
